// File: rtl/lrc_pkg.sv
package lrc_pkg;

  // Framing constants
  localparam int unsigned BUFFER_BYTES = 256;
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned MAX_PAYLOAD  = BUFFER_BYTES - HEADER_BYTES;
  localparam int unsigned CNT_W        = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0]  STX_CODE      = 8'h02;
  localparam logic [15:0] LEN_BIAS      = 16'd2;
  localparam logic [15:0] MIN_INTERCHAR = 16'd1000;
  localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCHAR     = 2'd1;

  localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] INTERCHAR_RST     = 16'd1000;

  // Input beat kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_PKT  = 3'd1,
    PH_LEN  = 3'd2,
    PH_CMD  = 3'd3,
    PH_DATA = 3'd4,
    PH_LRC  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_ACK     = 3'd2,
    EV_LRC_BAD = 3'd3,
    EV_LEN_BAD = 3'd4,
    EV_TIMEOUT = 3'd5
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  command;
    logic [15:0] packet_number;
    logic [7:0]  payload_length;
  } result_t;

endpackage

// File: rtl/lrc_if.sv
// Input beat: received byte or millisecond tick
interface lrc_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  modport source(output valid, action, rx_byte, input ready);
  modport sink(input valid, action, rx_byte, output ready);
endinterface

// Result beat
interface lrc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  command;
  logic [15:0] packet_number;
  logic [7:0]  payload_length;
  modport source(output valid, event_res, payload_byte, payload_index, command,
                 packet_number, payload_length, input ready);
  modport sink(input valid, event_res, payload_byte, payload_index, command,
               packet_number, payload_length, output ready);
endinterface

// Configuration write channel
interface lrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lrc_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/lrc_frame_receiver.sv
// Channel   Dir  Beat
// items     in   action (byte or tick), rx_byte
// results   out  event_res, payload_byte, payload_index, command,
//                packet_number, payload_length
// cfg       in   index, data (frame_timeout, gap_timeout)
//
// One result beat per input beat; a new beat is taken every cycle while results are not stalled.
// Each beat passes the input register, then the parse step into the result register.
// rst is synchronous; it restores register defaults and the hunt for STX.
// A stalled result holds the result register; the input register fills, then ready drops.
module lrc_frame_receiver (
  input  logic         clk,
  input  logic         rst,
  lrc_item_if.sink     items,
  lrc_result_if.source results,
  lrc_cfg_if.sink      cfg
);

  logic              in_valid;
  logic              in_action;
  logic [7:0]        in_byte;
  logic              out_valid;
  lrc_pkg::result_t  out_data;
  lrc_pkg::result_t  step_result;
  logic              out_free;
  logic              advance;
  logic [15:0]       frame_timeout;
  logic [15:0]       gap_timeout;

  lrc_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .frame_timeout (frame_timeout),
    .gap_timeout   (gap_timeout)
  );

  lrc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .action        (in_action),
    .rx_byte       (in_byte),
    .frame_timeout (frame_timeout),
    .gap_timeout   (gap_timeout),
    .result        (step_result)
  );

  // Flow control between the two register stages
  assign out_free    = !out_valid || results.ready;
  assign advance     = in_valid && out_free;
  assign items.ready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_action <= items.action;
      in_byte   <= items.rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign results.valid          = out_valid;
  assign results.event_res      = out_data.ev;
  assign results.payload_byte   = out_data.payload_byte;
  assign results.payload_index  = out_data.payload_index;
  assign results.command        = out_data.command;
  assign results.packet_number  = out_data.packet_number;
  assign results.payload_length = out_data.payload_length;

endmodule

// File: rtl/lrc_cfg_regs.sv
module lrc_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  lrc_cfg_if.sink     cfg,
  output logic [15:0] frame_timeout,
  output logic [15:0] gap_timeout
);

  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_timeout <= lrc_pkg::FRAME_TIMEOUT_RST;
      gap_timeout   <= lrc_pkg::INTERCHAR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lrc_pkg::CFG_FRAME_TIMEOUT: frame_timeout <= cfg.data;
        lrc_pkg::CFG_INTERCHAR:     gap_timeout   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/lrc_parser.sv
module lrc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              action,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       frame_timeout,
  input  logic [15:0]       gap_timeout,
  output lrc_pkg::result_t  result
);

  lrc_pkg::phase_t phase, phase_next;
  logic                      field_byte_count, field_byte_count_next;
  logic [15:0]               length_word, length_word_next;
  logic [lrc_pkg::CNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]                running_lrc, running_lrc_next;
  logic [7:0]                command_byte, command_byte_next;
  logic [15:0]               packet_word, packet_word_next;
  logic [15:0]               timeout_left, timeout_left_next;

  logic                      is_tick;
  logic                      timeout_hit;
  logic [15:0]               len_cur;
  logic [15:0]               len_shift;
  logic [15:0]               len_shift_payload;
  logic                      len_bad;
  logic [lrc_pkg::CNT_W:0]   count_inc;
  logic                      data_last;
  logic [15:0]               interchar_load;
  logic [15:0]               len_out;

  // Shared decode
  assign is_tick           = (action == lrc_pkg::ACT_TICK);
  assign timeout_hit       = (timeout_left <= 16'd1);
  assign len_cur           = length_word - lrc_pkg::LEN_BIAS;
  assign len_shift         = {length_word[7:0], rx_byte};
  assign len_shift_payload = len_shift - lrc_pkg::LEN_BIAS;
  assign len_bad           = (len_shift_payload > lrc_pkg::MAX_PAYLOAD_W);
  assign count_inc         = {1'b0, payload_count} + 1'b1;
  assign data_last         = (16'(count_inc) >= len_cur);
  assign interchar_load    = (gap_timeout < lrc_pkg::MIN_INTERCHAR)
                             ? lrc_pkg::MIN_INTERCHAR : gap_timeout;

  // Phase next state
  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      if (timeout_hit) phase_next = lrc_pkg::PH_HUNT;
    end else begin
      case (phase)
        lrc_pkg::PH_HUNT: begin
          if (rx_byte == lrc_pkg::STX_CODE) phase_next = lrc_pkg::PH_PKT;
        end
        lrc_pkg::PH_PKT: begin
          if (field_byte_count) phase_next = lrc_pkg::PH_LEN;
        end
        lrc_pkg::PH_LEN: begin
          if (field_byte_count) phase_next = len_bad ? lrc_pkg::PH_HUNT : lrc_pkg::PH_CMD;
        end
        lrc_pkg::PH_CMD: begin
          phase_next = (len_cur == 16'd0) ? lrc_pkg::PH_LRC : lrc_pkg::PH_DATA;
        end
        lrc_pkg::PH_DATA: begin
          if (data_last) phase_next = lrc_pkg::PH_LRC;
        end
        default: phase_next = lrc_pkg::PH_HUNT;
      endcase
    end
  end

  // Field capture, check byte, countdown and result
  always_comb begin
    field_byte_count_next = field_byte_count;
    length_word_next      = length_word;
    payload_count_next    = payload_count;
    running_lrc_next      = running_lrc;
    command_byte_next     = command_byte;
    packet_word_next      = packet_word;
    timeout_left_next     = timeout_left;
    result.ev             = lrc_pkg::EV_NONE;
    result.payload_byte   = 8'd0;
    result.payload_index  = 8'd0;
    if (is_tick) begin
      if (timeout_hit) begin
        result.ev             = lrc_pkg::EV_TIMEOUT;
        field_byte_count_next = 1'b0;
        timeout_left_next     = frame_timeout;
      end else begin
        timeout_left_next = timeout_left - 16'd1;
      end
    end else begin
      timeout_left_next = interchar_load;
      case (phase)
        lrc_pkg::PH_HUNT: begin
          if (rx_byte == lrc_pkg::STX_CODE) begin
            running_lrc_next      = lrc_pkg::STX_CODE;
            packet_word_next      = 16'd0;
            length_word_next      = 16'd0;
            command_byte_next     = 8'd0;
            payload_count_next    = '0;
            field_byte_count_next = 1'b0;
          end
        end
        lrc_pkg::PH_PKT: begin
          running_lrc_next      = running_lrc ^ rx_byte;
          packet_word_next      = {packet_word[7:0], rx_byte};
          field_byte_count_next = ~field_byte_count;
        end
        lrc_pkg::PH_LEN: begin
          running_lrc_next      = running_lrc ^ rx_byte;
          length_word_next      = len_shift;
          field_byte_count_next = ~field_byte_count;
          if (field_byte_count) begin
            if (len_bad) begin
              result.ev         = lrc_pkg::EV_LEN_BAD;
              timeout_left_next = frame_timeout;
            end else begin
              payload_count_next = '0;
            end
          end
        end
        lrc_pkg::PH_CMD: begin
          running_lrc_next  = running_lrc ^ rx_byte;
          command_byte_next = rx_byte;
        end
        lrc_pkg::PH_DATA: begin
          running_lrc_next     = running_lrc ^ rx_byte;
          result.ev            = lrc_pkg::EV_DATA;
          result.payload_byte  = rx_byte;
          result.payload_index = 8'(payload_count);
          payload_count_next   = count_inc[lrc_pkg::CNT_W-1:0];
        end
        lrc_pkg::PH_LRC: begin
          result.ev             = (rx_byte == running_lrc) ? lrc_pkg::EV_ACK
                                                           : lrc_pkg::EV_LRC_BAD;
          field_byte_count_next = 1'b0;
          timeout_left_next     = frame_timeout;
        end
        default: begin
          field_byte_count_next = 1'b0;
          timeout_left_next     = frame_timeout;
        end
      endcase
    end
    // Latched frame fields as they stand after this beat
    len_out               = length_word_next - lrc_pkg::LEN_BIAS;
    result.command        = command_byte_next;
    result.packet_number  = packet_word_next;
    result.payload_length = len_out[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lrc_pkg::PH_HUNT;
      field_byte_count <= 1'b0;
      length_word      <= 16'd0;
      payload_count    <= '0;
      running_lrc      <= 8'd0;
      command_byte     <= 8'd0;
      packet_word      <= 16'd0;
      timeout_left     <= lrc_pkg::FRAME_TIMEOUT_RST;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      length_word      <= length_word_next;
      payload_count    <= payload_count_next;
      running_lrc      <= running_lrc_next;
      command_byte     <= command_byte_next;
      packet_word      <= packet_word_next;
      timeout_left     <= timeout_left_next;
    end
  end

endmodule

// File: tb/sv/lrc_frame_checker.sv
`timescale 1ns / 1ps

module lrc_frame_checker (
  input  logic  clk,
  input  logic  rst,
  lrc_item_if   items,
  lrc_result_if results,
  lrc_cfg_if    cfg,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count
);
  import lrc_pkg::*;

  // Register copies
  logic [15:0] frame_ticks;
  logic [15:0] char_ticks;

  // Receiver state as the frame parser sees it
  phase_t      rx_phase;
  logic        hi_seen;
  logic [15:0] len_word;
  logic [7:0]  data_count;
  logic [7:0]  lrc_acc;
  logic [7:0]  cmd_byte;
  logic [15:0] pkt_word;
  logic [15:0] ticks_left;

  // Results owed by the block, oldest first
  result_t results_due[$];
  result_t want;

  task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
  endtask

  function automatic logic [15:0] declared_len();
    return len_word - LEN_BIAS;
  endfunction

  function automatic void restart_hunt();
    rx_phase   = PH_HUNT;
    hi_seen    = 1'b0;
    ticks_left = frame_ticks;
  endfunction

  // One input beat through the parser; returns the result beat it causes
  function automatic result_t parse_beat(input logic act, input logic [7:0] b);
    result_t res;
    res    = '0;
    res.ev = EV_NONE;
    if (act == ACT_TICK) begin
      // countdown: 1 or 0 left means expiry
      if (ticks_left <= 16'd1) begin
        res.ev = EV_TIMEOUT;
        restart_hunt();
      end else begin
        ticks_left = ticks_left - 16'd1;
      end
    end else begin
      ticks_left = (char_ticks < MIN_INTERCHAR) ? MIN_INTERCHAR : char_ticks;
      case (rx_phase)
        PH_HUNT: begin
          if (b == STX_CODE) begin
            lrc_acc    = STX_CODE;
            pkt_word   = '0;
            len_word   = '0;
            cmd_byte   = '0;
            data_count = '0;
            hi_seen    = 1'b0;
            rx_phase   = PH_PKT;
          end
        end
        PH_PKT: begin
          lrc_acc  = lrc_acc ^ b;
          pkt_word = {pkt_word[7:0], b};
          if (hi_seen) begin
            hi_seen  = 1'b0;
            rx_phase = PH_LEN;
          end else begin
            hi_seen = 1'b1;
          end
        end
        PH_LEN: begin
          lrc_acc  = lrc_acc ^ b;
          len_word = {len_word[7:0], b};
          if (hi_seen) begin
            hi_seen = 1'b0;
            // wrap of length words below 2 lands here too
            if (declared_len() > MAX_PAYLOAD_W) begin
              res.ev = EV_LEN_BAD;
              restart_hunt();
            end else begin
              data_count = '0;
              rx_phase   = PH_CMD;
            end
          end else begin
            hi_seen = 1'b1;
          end
        end
        PH_CMD: begin
          lrc_acc  = lrc_acc ^ b;
          cmd_byte = b;
          rx_phase = (declared_len() == 16'd0) ? PH_LRC : PH_DATA;
        end
        PH_DATA: begin
          lrc_acc           = lrc_acc ^ b;
          res.ev            = EV_DATA;
          res.payload_byte  = b;
          res.payload_index = data_count;
          data_count        = data_count + 8'd1;
          if ({8'd0, data_count} >= declared_len())
            rx_phase = PH_LRC;
        end
        PH_LRC: begin
          res.ev = (b == lrc_acc) ? EV_ACK : EV_LRC_BAD;
          restart_hunt();
        end
        default: restart_hunt();
      endcase
    end
    res.command        = cmd_byte;
    res.packet_number  = pkt_word;
    res.payload_length = 8'(declared_len());
    return res;
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      frame_ticks = FRAME_TIMEOUT_RST;
      char_ticks  = INTERCHAR_RST;
      rx_phase    = PH_HUNT;
      hi_seen     = 1'b0;
      len_word    = '0;
      data_count  = '0;
      lrc_acc     = '0;
      cmd_byte    = '0;
      pkt_word    = '0;
      ticks_left  = FRAME_TIMEOUT_RST;
      results_due.delete();
    end else begin
      // result first: it cannot belong to a beat taken at this same edge
      if (results.valid && results.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing due, event", 16'd0,
                          16'(results.event_res));
        end else begin
          want = results_due.pop_front();
          checked_count++;
          if (results.event_res !== want.ev)
            report_mismatch("event", 16'(want.ev), 16'(results.event_res));
          if (results.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 16'(want.payload_byte),
                            16'(results.payload_byte));
          if (results.payload_index !== want.payload_index)
            report_mismatch("payload_index", 16'(want.payload_index),
                            16'(results.payload_index));
          if (results.command !== want.command)
            report_mismatch("command", 16'(want.command), 16'(results.command));
          if (results.packet_number !== want.packet_number)
            report_mismatch("packet_number", want.packet_number, results.packet_number);
          if (results.payload_length !== want.payload_length)
            report_mismatch("payload_length", 16'(want.payload_length),
                            16'(results.payload_length));
        end
      end
      // register writes; unused indexes are dropped
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_TIMEOUT: frame_ticks = cfg.data;
          CFG_INTERCHAR:     char_ticks  = cfg.data;
          default: ;
        endcase
      end
      if (items.valid && items.ready)
        results_due.push_back(parse_beat(items.action, items.rx_byte));
    end
    pending_count <= results_due.size();
  end

endmodule

// File: tb/sv/tb_lrc_frame_receiver.sv
`timescale 1ns / 1ps

module tb_lrc_frame_receiver;
  import lrc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_BEATS = 10;
  // register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
  localparam int FILL_RANDOM = -1;

  logic clk;
  logic rst;

  lrc_item_if   items_ch();
  lrc_result_if results_ch();
  lrc_cfg_if    cfg_ch();

  int fail_count;
  int pending_count;
  int checked_count;

  bit gaps_on;
  bit stalls_on;
  int beats_sent;
  int ticks_sent;
  int frames_sent;
  int settings_used;
  int idle_cycles;

  lrc_frame_receiver u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  lrc_frame_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .items         (items_ch),
    .results       (results_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result-side back-pressure in random bursts
  initial begin : result_stall
    int hold_cnt;
    hold_cnt = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt != 0) begin
        hold_cnt--;
        results_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(0, 4);
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: no beat on any channel for too long
  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results owed",
               idle_cycles, pending_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic act, input logic [7:0] b);
    int gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        items_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    items_ch.valid   <= 1'b1;
    items_ch.action  <= act;
    items_ch.rx_byte <= b;
    do @(posedge clk); while (!items_ch.ready);
    beats_sent++;
    if (act == ACT_TICK)
      ticks_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(ACT_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    items_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One frame: header, command, payload, LRC. A bad length stops after the
  // length word; cut truncates; lrc_flip corrupts the check byte.
  task automatic send_frame(input logic [15:0] pkt, input logic [15:0] len_w,
                            input logic [7:0] cmd, input int cut,
                            input logic [7:0] lrc_flip, input bit pause_mid,
                            input int fill);
    logic [7:0]  fb[$];
    logic [7:0]  acc;
    logic [15:0] body;
    body = len_w - LEN_BIAS;
    fb.push_back(STX_CODE);
    fb.push_back(pkt[15:8]);
    fb.push_back(pkt[7:0]);
    fb.push_back(len_w[15:8]);
    fb.push_back(len_w[7:0]);
    if (body <= MAX_PAYLOAD_W) begin
      fb.push_back(cmd);
      for (int i = 0; i < int'(body); i++)
        fb.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      acc = '0;
      foreach (fb[i]) acc = acc ^ fb[i];
      fb.push_back(acc ^ lrc_flip);
    end
    if (cut > 0)
      while (fb.size() > cut) void'(fb.pop_back());
    foreach (fb[i]) begin
      // ticks between bytes only decrement the inter-character count
      if (i > 0 && $urandom_range(0, 11) == 0)
        send_ticks($urandom_range(1, 3));
      if (pause_mid && i == 5)
        settle();
      send_beat(ACT_BYTE, fb[i]);
    end
    frames_sent++;
  endtask

  // One random chunk of traffic, mostly well-formed frames
  task automatic random_unit();
    int          r;
    int          n;
    logic [15:0] lw;
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 16);
    if (r < 60) begin
      send_frame(16'($urandom), 16'(n + 2), 8'($urandom), 0, 8'h00, 1'b0, FILL_RANDOM);
    end else if (r < 70) begin
      send_frame(16'($urandom), 16'(n + 2), 8'($urandom), 0,
                 8'($urandom_range(1, 255)), 1'b0, FILL_RANDOM);
    end else if (r < 78) begin
      case ($urandom_range(0, 3))
        0:       lw = 16'($urandom_range(0, 1));
        1:       lw = MAX_PAYLOAD_W + LEN_BIAS + 16'd1;
        2:       lw = 16'($urandom_range(253, 65535));
        default: lw = 16'hFFFF;
      endcase
      send_frame(16'($urandom), lw, 8'($urandom), 0, 8'h00, 1'b0, FILL_RANDOM);
    end else if (r < 85) begin
      send_frame(16'($urandom), 16'(n + 2), 8'($urandom), $urandom_range(1, n + 6),
                 8'h00, 1'b0, FILL_RANDOM);
    end else if (r < 93) begin
      send_ticks($urandom_range(1, 8));
    end else begin
      repeat ($urandom_range(1, 4)) send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [15:0] ft, input logic [15:0] ic,
                           input bit idle, input bit junk, input int n_beats);
    int start;
    settle();
    cfg_write(CFG_FRAME_TIMEOUT, ft);
    cfg_write(CFG_INTERCHAR, ic);
    if (junk) begin
      cfg_write(CFG_UNUSED_A, 16'hFFFF);
      cfg_write(CFG_UNUSED_B, 16'hFFFF);
    end
    settings_used++;
    gaps_on   = idle;
    stalls_on = idle;
    start = beats_sent;
    while (beats_sent - start < n_beats) random_unit();
  endtask

  initial begin
    rst              = 1'b1;
    items_ch.valid   = 1'b0;
    items_ch.action  = ACT_BYTE;
    items_ch.rx_byte = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_FRAME_TIMEOUT;
    cfg_ch.data      = '0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    settings_used    = 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults after reset
    send_beat(ACT_TICK, 8'hFF);
    send_beat(ACT_BYTE, 8'hFD);
    // empty payload, all-ones packet number and command, good check byte
    send_frame(16'hFFFF, 16'h0002, 8'hFF, 0, 8'h00, 1'b0, FILL_RANDOM);
    // length word zero wraps past the buffer
    send_frame(16'h0000, 16'h0000, 8'h00, 0, 8'h00, 1'b0, FILL_RANDOM);
    // one payload byte, corrupted check byte
    send_frame(16'h1234, 16'h0003, 8'h00, 0, 8'h80, 1'b0, 8'hFF);
    // one byte over the largest payload
    send_frame(16'h0000, MAX_PAYLOAD_W + LEN_BIAS + 16'd1, 8'h00, 0, 8'h00, 1'b0,
               FILL_RANDOM);

    // Random phases over several register settings
    run_phase(16'd1, 16'd1000, 1'b1, 1'b1, PHASE_BEATS);
    run_phase(16'd0, 16'd0, 1'b1, 1'b0, PHASE_BEATS);
    run_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, PHASE_BEATS);
    // largest payload, with the sender holding off mid-frame until drained
    send_frame(16'($urandom), MAX_PAYLOAD_W + LEN_BIAS, 8'($urandom), 0, 8'h00, 1'b1,
               FILL_RANDOM);
    run_phase(16'd5, 16'd999, 1'b1, 1'b0, PHASE_BEATS);
    repeat (3)
      run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1000, 65535)), 1'b1, 1'b0,
                PHASE_BEATS);
    run_phase(16'($urandom_range(1, 12)), 16'd1000, 1'b0, 1'b0, PHASE_BEATS);

    settle();
    repeat (10) @(negedge clk);
    $display("Sent %0d beats: %0d frames or fragments, %0d ticks, over %0d register settings",
             beats_sent, frames_sent, ticks_sent, settings_used);
    $display("Checked %0d result beats, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
